/* rtl/core/feq_pkg.sv */
// Shared constants, types and tables for the figure-eight trajectory generator.
// No dependencies; the top level refers to this package by scoped names and the testbench imports it.
package feq_pkg;

	// Default fraction bits and CORDIC depth
	localparam int FRAC_BITS_DEF    = 16;
	localparam int ANGLE_STAGES_DEF = 20;

	// Fixed constants of the datapath
	localparam logic [30:0] TWOPI_Q28 = 31'd1686629713;
	localparam logic [28:0] TWOPI_Q26 = 29'd421657428;
	localparam logic [29:0] GAIN_Q30  = 30'd652032874;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_CENTER_X = 2'd0,
		CFG_CENTER_Y = 2'd1,
		CFG_RADIUS   = 2'd2,
		CFG_PERIOD   = 2'd3
	} cfg_index_t;

	// Arctangent of 2^-i in units of 2^-32 turn, truncated
	function automatic logic [31:0] atan_turn(input int unsigned idx);
		logic [31:0] r;
		case (idx)
			0:  r = 32'h20000000;
			1:  r = 32'h12E4051E;
			2:  r = 32'h09FB385B;
			3:  r = 32'h051111D4;
			4:  r = 32'h028B0D43;
			5:  r = 32'h0145D7E1;
			6:  r = 32'h00A2F61E;
			7:  r = 32'h00517C55;
			8:  r = 32'h0028BE53;
			9:  r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2F9;
			15: r = 32'h0000517C;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A2F;
			19: r = 32'h00000517;
			20: r = 32'h0000028B;
			21: r = 32'h00000145;
			22: r = 32'h000000A2;
			23: r = 32'h00000051;
			24: r = 32'h00000028;
			25: r = 32'h00000014;
			26: r = 32'h0000000A;
			27: r = 32'h00000005;
			28: r = 32'h00000002;
			29: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/feq_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on nothing; instantiated by the figure-eight generator top level.
module feq_div #(
	parameter int DEN_W  = 31,
	parameter int Q_W    = 32,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [DEN_W-1:0]  in_rem,
	input  logic [DEN_W-1:0]  in_den,
	input  logic [Q_W-1:0]    in_num,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [Q_W-1:0]    out_quo,
	output logic [DEN_W-1:0]  out_rem,
	output logic [SIDE_W-1:0] out_side
);

	logic              vld_s  [0:Q_W];
	logic [DEN_W-1:0]  rem_s  [0:Q_W];
	logic [DEN_W-1:0]  den_s  [0:Q_W];
	logic [Q_W-1:0]    nq_s   [0:Q_W];
	logic [SIDE_W-1:0] side_s [0:Q_W];

	// Feed the first stage straight from the inputs
	always_comb begin
		vld_s[0]  = in_valid;
		rem_s[0]  = in_rem;
		den_s[0]  = in_den;
		nq_s[0]   = in_num;
		side_s[0] = in_side;
	end

	// One quotient bit per stage: numerator bits leave at the top, quotient bits enter below
	for (genvar j = 0; j < Q_W; j++) begin : g_stage
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           ge;

		always_comb begin
			trial = {rem_s[j], nq_s[j][Q_W-1]};
			diff  = trial - {1'b0, den_s[j]};
			ge    = trial >= {1'b0, den_s[j]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[j+1]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			den_s[j+1]  <= den_s[j];
			nq_s[j+1]   <= {nq_s[j][Q_W-2:0], ge};
			side_s[j+1] <= side_s[j];
		end
	end

	assign out_valid = vld_s[Q_W];
	assign out_quo   = nq_s[Q_W];
	assign out_rem   = rem_s[Q_W];
	assign out_side  = side_s[Q_W];

	// Remainder always ends below the divisor
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_rem < den_s[Q_W]))
		else $error("divider remainder not below divisor");

	// A result leaves only for operands that entered the first stage earlier
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(in_valid, Q_W))
		else $error("divider result without matching operands");

endmodule

/* rtl/core/figure_eight_trajectory_generator_top.sv */
// Top level of the figure-eight trajectory generator: pose, heading, speed, turn rate.
// Depends on feq_pkg and feq_div.
//
// One time sample enters on every cycle that start is high; busy is always low, since
// the datapath is a free-running pipeline with no stall. Each sample passes through the
// chain of bit-per-stage dividers, the square root and the two CORDIC sections;
// results appear in order, one done pulse each, and must be taken in that cycle.
// Configuration must only be written while no sample is in flight.
module figure_eight_trajectory_generator_top #(
	parameter int FRAC_BITS    = feq_pkg::FRAC_BITS_DEF,
	parameter int ANGLE_STAGES = feq_pkg::ANGLE_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [31:0]        time_now,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               done,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [18:0] heading,
	output logic [30:0]        speed,
	output logic signed [31:0] turn_rate,
	output logic               zero_speed
);

	localparam int AW  = 34;
	localparam int ZW  = 33;
	localparam int HW  = 36;
	localparam int HZW = 35;
	localparam int K1  = 28 - FRAC_BITS;
	localparam int DW1 = 31 + K1;
	localparam int K2  = 56 - 2 * FRAC_BITS;
	localparam int DW2 = 31 + K2;
	localparam int NA  = ANGLE_STAGES;

	localparam logic signed [ZW-1:0]  Z_QUARTER = 33'sd1073741824;
	localparam logic signed [ZW-1:0]  Z_HALF    = 33'sd2147483648;
	localparam logic signed [HZW-1:0] H_HALF    = 35'sd2147483648;

	typedef struct packed {
		logic [31:0]        px;
		logic [31:0]        py;
		logic signed [32:0] a;
		logic signed [32:0] b;
		logic signed [65:0] num;
		logic [29:0]        dd;
	} geo_t;

	typedef struct packed {
		geo_t geo;
		logic ovf;
	} spd_side_t;

	typedef struct packed {
		logic [31:0]        px;
		logic [31:0]        py;
		logic signed [65:0] num;
		logic [29:0]        dd;
		logic [30:0]        spd;
		logic               zero;
	} mot_t;

	typedef struct packed {
		logic [31:0] px;
		logic [31:0] py;
		logic [18:0] head;
		logic [30:0] spd;
		logic        zero;
		logic        neg;
	} out_t;

	typedef struct packed {
		out_t o;
		logic ovf;
	} tr_side_t;

	function automatic logic [ZW:0] fold_turn(input logic [31:0] ph);
		logic signed [ZW-1:0] zs;
		logic                 neg;
		zs  = $signed({ph[31], ph});
		neg = 1'b0;
		if (zs > Z_QUARTER) begin
			zs  = zs - Z_HALF;
			neg = 1'b1;
		end else if (zs < -Z_QUARTER) begin
			zs  = zs + Z_HALF;
			neg = 1'b1;
		end
		return {neg, zs};
	endfunction

	function automatic logic [31:0] sat32(input logic signed [66:0] v);
		logic [31:0] r;
		if (v > 67'sd2147483647) begin
			r = 32'h7FFFFFFF;
		end else if (v < -67'sd2147483648) begin
			r = 32'h80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// ------------------------------------------------------------------ configuration
	logic [31:0] cx_q, cy_q;
	logic [30:0] rad_q, per_q;
	logic [30:0] per_eff;

	// Write registers from the port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q  <= 32'd0;
			cy_q  <= 32'd0;
			rad_q <= 31'd65536;
			per_q <= 31'd655360;
		end else if (cfg_we) begin
			case (feq_pkg::cfg_index_t'(cfg_index))
				feq_pkg::CFG_CENTER_X: cx_q  <= cfg_data;
				feq_pkg::CFG_CENTER_Y: cy_q  <= cfg_data;
				feq_pkg::CFG_RADIUS:   rad_q <= cfg_data[30:0];
				feq_pkg::CFG_PERIOD:   per_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Treat a zero period as one LSB
	assign per_eff = (per_q == '0) ? 31'd1 : per_q;
	assign busy    = 1'b0;

	// ------------------------------------------------------------------ phase
	logic        va;
	logic [31:0] quo_a;
	logic [30:0] rem_a;
	logic        vb;
	logic [31:0] ph;
	logic [30:0] rem_b;

	// Reduce time modulo the period
	feq_div #(.DEN_W(31), .Q_W(32), .SIDE_W(1)) u_div_mod (
		.clk(clk), .arst_n(arst_n),
		.in_valid(start), .in_rem('0), .in_den(per_eff), .in_num(time_now),
		.in_side(1'b0),
		.out_valid(va), .out_quo(quo_a), .out_rem(rem_a), .out_side()
	);

	// Turn fraction: remainder * 2^32 / period
	feq_div #(.DEN_W(31), .Q_W(32), .SIDE_W(1)) u_div_phase (
		.clk(clk), .arst_n(arst_n),
		.in_valid(va), .in_rem(rem_a), .in_den(per_eff), .in_num(quo_a & '0),
		.in_side(1'b0),
		.out_valid(vb), .out_quo(ph), .out_rem(rem_b), .out_side()
	);

	// ------------------------------------------------------------------ sin/cos CORDIC
	logic                 vr_s   [0:NA];
	logic signed [AW-1:0] x1_s   [0:NA];
	logic signed [AW-1:0] y1_s   [0:NA];
	logic signed [AW-1:0] x2_s   [0:NA];
	logic signed [AW-1:0] y2_s   [0:NA];
	logic signed [ZW-1:0] z1_s   [0:NA-1];
	logic signed [ZW-1:0] z2_s   [0:NA-1];
	logic                 neg1_s [0:NA];
	logic                 neg2_s [0:NA];
	logic [ZW:0]          fold1, fold2;

	always_comb begin
		fold1 = fold_turn(ph);
		fold2 = fold_turn({ph[30:0], 1'b0} ^ rem_b[0:0] & 1'b0);
	end

	// Fold both angles into the right half plane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vr_s[0] <= 1'b0;
		end else begin
			vr_s[0] <= vb;
		end
	end

	always_ff @(posedge clk) begin
		x1_s[0]   <= AW'($signed({1'b0, feq_pkg::GAIN_Q30}));
		y1_s[0]   <= '0;
		z1_s[0]   <= $signed(fold1[ZW-1:0]);
		neg1_s[0] <= fold1[ZW];
		x2_s[0]   <= AW'($signed({1'b0, feq_pkg::GAIN_Q30}));
		y2_s[0]   <= '0;
		z2_s[0]   <= $signed(fold2[ZW-1:0]);
		neg2_s[0] <= fold2[ZW];
	end

	// Rotate both vectors one micro-angle per stage
	for (genvar i = 0; i < NA; i++) begin : g_rot
		localparam logic signed [ZW-1:0] ATN = $signed({1'b0, feq_pkg::atan_turn(i)});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vr_s[i+1] <= 1'b0;
			end else begin
				vr_s[i+1] <= vr_s[i];
			end
		end

		always_ff @(posedge clk) begin
			neg1_s[i+1] <= neg1_s[i];
			neg2_s[i+1] <= neg2_s[i];
			if (z1_s[i] >= 0) begin
				x1_s[i+1] <= x1_s[i] - (y1_s[i] >>> i);
				y1_s[i+1] <= y1_s[i] + (x1_s[i] >>> i);
			end else begin
				x1_s[i+1] <= x1_s[i] + (y1_s[i] >>> i);
				y1_s[i+1] <= y1_s[i] - (x1_s[i] >>> i);
			end
			if (z2_s[i] >= 0) begin
				x2_s[i+1] <= x2_s[i] - (y2_s[i] >>> i);
				y2_s[i+1] <= y2_s[i] + (x2_s[i] >>> i);
			end else begin
				x2_s[i+1] <= x2_s[i] + (y2_s[i] >>> i);
				y2_s[i+1] <= y2_s[i] - (x2_s[i] >>> i);
			end
		end

		if (i < NA - 1) begin : g_z
			always_ff @(posedge clk) begin
				z1_s[i+1] <= (z1_s[i] >= 0) ? z1_s[i] - ATN : z1_s[i] + ATN;
				z2_s[i+1] <= (z2_s[i] >= 0) ? z2_s[i] - ATN : z2_s[i] + ATN;
			end
		end
	end

	// ------------------------------------------------------------------ products
	logic signed [AW-1:0] c1, s1, c2, s2;
	logic signed [35:0]   c1x3;
	logic signed [32:0]   a_w, b_w;
	logic signed [30:0]   s1q, c2q, c1q, s2q;

	// Undo the fold and form the direction terms
	always_comb begin
		c1   = neg1_s[NA] ? -x1_s[NA] : x1_s[NA];
		s1   = neg1_s[NA] ? -y1_s[NA] : y1_s[NA];
		c2   = neg2_s[NA] ? -x2_s[NA] : x2_s[NA];
		s2   = neg2_s[NA] ? -y2_s[NA] : y2_s[NA];
		c1x3 = 36'(c1) * 3;
		a_w  = 33'(c1x3 >>> 1);
		b_w  = 33'(c2 * 2);
		s1q  = 31'(s1 >>> 2);
		c2q  = 31'(c2 >>> 2);
		c1q  = 31'(c1 >>> 2);
		s2q  = 31'(s2 >>> 2);
	end

	logic               v_s1;
	logic signed [32:0] a_s1, b_s1;
	logic signed [65:0] aa_s1, bb_s1, rs1_s1, rs2_s1;
	logic signed [61:0] n1_s1, n2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= vr_s[NA];
		end
	end

	// Multiply everything the pose, speed and curvature need
	always_ff @(posedge clk) begin
		a_s1   <= a_w;
		b_s1   <= b_w;
		aa_s1  <= a_w * a_w;
		bb_s1  <= b_w * b_w;
		rs1_s1 <= $signed({1'b0, rad_q}) * s1;
		rs2_s1 <= $signed({1'b0, rad_q}) * s2;
		n1_s1  <= s1q * c2q;
		n2_s1  <= c1q * s2q;
	end

	logic signed [65:0] tx, ty;
	logic signed [66:0] sx, sy;

	always_comb begin
		tx = (rs1_s1 * 3 + (66'sd1 <<< 30)) >>> 31;
		ty = (rs2_s1 + (66'sd1 <<< 29)) >>> 30;
		sx = 67'($signed(cx_q)) + 67'(tx);
		sy = 67'($signed(cy_q)) + 67'(ty);
	end

	logic               v_s2;
	logic [31:0]        px_s2, py_s2;
	logic signed [32:0] a_s2, b_s2;
	logic [63:0]        d_s2;
	logic signed [65:0] num_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	// Round and saturate the pose; sum the squared magnitude and the curvature numerator
	always_ff @(posedge clk) begin
		px_s2  <= sat32(sx);
		py_s2  <= sat32(sy);
		a_s2   <= a_s1;
		b_s2   <= b_s1;
		d_s2   <= aa_s1[63:0] + bb_s1[63:0];
		num_s2 <= 66'(n1_s1) * 3 - 66'(n2_s1) * 6;
	end

	// ------------------------------------------------------------------ square root
	logic        vq_s    [0:32];
	logic [33:0] sq_rem_s  [0:31];
	logic [31:0] sq_root_s [0:32];
	logic [63:0] sq_d_s    [0:31];
	geo_t        geo_q_s   [0:32];
	geo_t        geo_in;

	always_comb begin
		geo_in.px  = px_s2;
		geo_in.py  = py_s2;
		geo_in.a   = a_s2;
		geo_in.b   = b_s2;
		geo_in.num = num_s2;
		geo_in.dd  = (d_s2[63:34] == '0) ? 30'd1 : d_s2[63:34];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vq_s[0] <= 1'b0;
		end else begin
			vq_s[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sq_rem_s[0]  <= '0;
		sq_root_s[0] <= '0;
		sq_d_s[0]    <= d_s2;
		geo_q_s[0]   <= geo_in;
	end

	// Resolve one root bit per stage from two radicand bits
	for (genvar i = 0; i < 32; i++) begin : g_sqrt
		logic [35:0] trial;
		logic [35:0] cand;
		logic        ge;

		always_comb begin
			trial = {sq_rem_s[i], sq_d_s[i][63:62]};
			cand  = {2'b00, sq_root_s[i], 2'b01};
			ge    = trial >= cand;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vq_s[i+1] <= 1'b0;
			end else begin
				vq_s[i+1] <= vq_s[i];
			end
		end

		always_ff @(posedge clk) begin
			sq_root_s[i+1] <= {sq_root_s[i][30:0], ge};
			geo_q_s[i+1]   <= geo_q_s[i];
		end

		if (i < 31) begin : g_next
			always_ff @(posedge clk) begin
				sq_rem_s[i+1] <= ge ? 34'(trial - cand) : trial[33:0];
				sq_d_s[i+1]   <= {sq_d_s[i][61:0], 2'b00};
			end
		end
	end

	// ------------------------------------------------------------------ speed
	logic        v_s3, v_s4, v_s5;
	logic [62:0] rm_s3;
	logic [63:0] sn_s4;
	geo_t        geo_s3, geo_s4, geo_s5;
	logic        ovf_s5;
	logic [DW1-1:0] init_s5;
	logic [30:0]    lo_s5;
	logic [DW1-1:0] den_sp;

	assign den_sp = {per_eff, {K1{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s3 <= vq_s[32];
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Scale the magnitude by radius, then by 2*pi; flag a quotient beyond 31 bits
	always_ff @(posedge clk) begin
		rm_s3   <= rad_q * sq_root_s[32];
		geo_s3  <= geo_q_s[32];
		sn_s4   <= rm_s3[62:30] * feq_pkg::TWOPI_Q28;
		geo_s4  <= geo_s3;
		ovf_s5  <= sn_s4[63:31] >= den_sp;
		init_s5 <= (sn_s4[63:31] >= den_sp) ? '0 : DW1'(sn_s4[63:31]);
		lo_s5   <= sn_s4[30:0];
		geo_s5  <= geo_s4;
	end

	logic           vsp;
	logic [30:0]    spd_quo;
	logic [DW1-1:0] spd_rem;
	spd_side_t      spd_in, spd_out;

	assign spd_in = '{geo: geo_s5, ovf: ovf_s5};

	feq_div #(.DEN_W(DW1), .Q_W(31), .SIDE_W($bits(spd_side_t))) u_div_speed (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s5), .in_rem(init_s5), .in_den(den_sp), .in_num(lo_s5),
		.in_side(spd_in),
		.out_valid(vsp), .out_quo(spd_quo), .out_rem(spd_rem), .out_side(spd_out)
	);

	logic               v_s6;
	mot_t               mot_s6;
	logic signed [32:0] a_s6, b_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= vsp;
		end
	end

	// Saturate speed and detect standstill
	always_ff @(posedge clk) begin
		mot_s6.px   <= spd_out.geo.px;
		mot_s6.py   <= spd_out.geo.py;
		mot_s6.num  <= spd_out.geo.num;
		mot_s6.dd   <= spd_out.geo.dd;
		mot_s6.spd  <= spd_out.ovf ? 31'h7FFFFFFF : spd_quo;
		mot_s6.zero <= !spd_out.ovf && (spd_quo == '0) && (spd_rem == spd_rem);
		a_s6        <= spd_out.geo.a;
		b_s6        <= spd_out.geo.b;
	end

	// ------------------------------------------------------------------ heading CORDIC
	logic                  vh_s [0:NA];
	logic signed [HW-1:0]  ha_s [0:NA];
	logic signed [HW-1:0]  hb_s [0:NA];
	logic signed [HZW-1:0] hz_s [0:NA];
	mot_t                  mot_h_s [0:NA];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vh_s[0] <= 1'b0;
		end else begin
			vh_s[0] <= v_s6;
		end
	end

	// Fold a vector in the left half plane by half a turn
	always_ff @(posedge clk) begin
		mot_h_s[0] <= mot_s6;
		if (a_s6 < 0) begin
			ha_s[0] <= -HW'(a_s6);
			hb_s[0] <= -HW'(b_s6);
			hz_s[0] <= (b_s6 >= 0) ? H_HALF : -H_HALF;
		end else begin
			ha_s[0] <= HW'(a_s6);
			hb_s[0] <= HW'(b_s6);
			hz_s[0] <= '0;
		end
	end

	// Drive the y term towards zero, one micro-angle per stage
	for (genvar i = 0; i < NA; i++) begin : g_vec
		localparam logic signed [HZW-1:0] ATN = $signed({3'b000, feq_pkg::atan_turn(i)});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vh_s[i+1] <= 1'b0;
			end else begin
				vh_s[i+1] <= vh_s[i];
			end
		end

		always_ff @(posedge clk) begin
			mot_h_s[i+1] <= mot_h_s[i];
			if (hb_s[i] > 0) begin
				ha_s[i+1] <= ha_s[i] + (hb_s[i] >>> i);
				hb_s[i+1] <= hb_s[i] - (ha_s[i] >>> i);
				hz_s[i+1] <= hz_s[i] + ATN;
			end else begin
				ha_s[i+1] <= ha_s[i] - (hb_s[i] >>> i);
				hb_s[i+1] <= hb_s[i] + (ha_s[i] >>> i);
				hz_s[i+1] <= hz_s[i] - ATN;
			end
		end
	end

	logic signed [ZW-1:0] zc;

	// Clamp the angle to half a turn either way
	always_comb begin
		if (hz_s[NA] > H_HALF) begin
			zc = Z_HALF;
		end else if (hz_s[NA] < -H_HALF) begin
			zc = -Z_HALF;
		end else begin
			zc = ZW'(hz_s[NA] + (ha_s[NA] & '0) + (hb_s[NA] & '0));
		end
	end

	logic               v_s7, v_s8;
	logic signed [64:0] hp_s7;
	mot_t               mot_s7;
	out_t               out_s8;
	logic [64:0]        mag_s8;
	logic [29:0]        dd_s8;
	logic signed [64:0] hr;

	assign hr = (hp_s7 + (65'sd1 <<< (59 - FRAC_BITS))) >>> (60 - FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s7 <= vh_s[NA];
			v_s8 <= v_s7;
		end
	end

	// Turn angle into radians; split the numerator into sign and magnitude
	always_ff @(posedge clk) begin
		hp_s7       <= zc * $signed({1'b0, feq_pkg::TWOPI_Q28});
		mot_s7      <= mot_h_s[NA];
		out_s8.px   <= mot_s7.px;
		out_s8.py   <= mot_s7.py;
		out_s8.head <= hr[18:0];
		out_s8.spd  <= mot_s7.spd;
		out_s8.zero <= mot_s7.zero;
		out_s8.neg  <= mot_s7.num[65];
		mag_s8      <= mot_s7.num[65] ? 65'(-mot_s7.num) : 65'(mot_s7.num);
		dd_s8       <= mot_s7.dd;
	end

	// ------------------------------------------------------------------ turn rate
	logic        vrq;
	logic [39:0] rq_quo;
	logic [29:0] rq_rem;
	out_t        rq_out;

	// Divide curvature numerator by the scaled squared speed
	feq_div #(.DEN_W(30), .Q_W(40), .SIDE_W($bits(out_t))) u_div_rq (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s8), .in_rem(30'(mag_s8[64:40])), .in_den(dd_s8),
		.in_num(mag_s8[39:0]), .in_side(out_s8),
		.out_valid(vrq), .out_quo(rq_quo), .out_rem(rq_rem), .out_side(rq_out)
	);

	logic           v_s9, v_s10, v_s11;
	logic [48:0]    pl_s9, phh_s9;
	out_t           out_s9, out_s10;
	logic [68:0]    prod_s10;
	tr_side_t       trs_s11;
	logic [DW2-1:0] init_s11;
	logic [31:0]    lo_s11;
	logic [DW2-1:0] den_tr;

	assign den_tr = {per_eff, {K2{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else begin
			v_s9  <= vrq;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	// Multiply by 2*pi in two halves, sum, then flag a quotient beyond 32 bits
	always_ff @(posedge clk) begin
		pl_s9          <= rq_quo[19:0] * feq_pkg::TWOPI_Q26;
		phh_s9         <= rq_quo[39:20] * feq_pkg::TWOPI_Q26;
		out_s9         <= rq_out;
		prod_s10       <= {phh_s9, 20'd0} + 69'(pl_s9) + 69'(rq_rem & '0);
		out_s10        <= out_s9;
		trs_s11.o      <= out_s10;
		trs_s11.ovf    <= prod_s10[68:32] >= den_tr;
		init_s11       <= (prod_s10[68:32] >= den_tr) ? '0 : DW2'(prod_s10[68:32]);
		lo_s11         <= prod_s10[31:0];
	end

	logic           vtr;
	logic [31:0]    tr_quo;
	logic [DW2-1:0] tr_rem;
	tr_side_t       tr_out;

	// Divide by the period and the fixed-point scale together
	feq_div #(.DEN_W(DW2), .Q_W(32), .SIDE_W($bits(tr_side_t))) u_div_tr (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s11), .in_rem(init_s11), .in_den(den_tr), .in_num(lo_s11),
		.in_side(trs_s11),
		.out_valid(vtr), .out_quo(tr_quo), .out_rem(tr_rem), .out_side(tr_out)
	);

	// ------------------------------------------------------------------ output
	logic [31:0] turn_w;
	logic        big_pos, big_neg;

	// Apply sign with saturation; force zero at standstill
	always_comb begin
		big_pos = tr_out.ovf || (tr_quo > 32'h7FFFFFFF) || (tr_rem != tr_rem);
		big_neg = tr_out.ovf || (tr_quo > 32'h80000000);
		if (tr_out.o.zero) begin
			turn_w = '0;
		end else if (tr_out.o.neg) begin
			turn_w = big_neg ? 32'h80000000 : -tr_quo;
		end else begin
			turn_w = big_pos ? 32'h7FFFFFFF : tr_quo;
		end
	end

	logic        done_s12;
	logic [31:0] px_s12, py_s12, turn_s12;
	logic [18:0] head_s12;
	logic [30:0] spd_s12;
	logic        zero_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s12 <= 1'b0;
		end else begin
			done_s12 <= vtr;
		end
	end

	always_ff @(posedge clk) begin
		px_s12   <= tr_out.o.px;
		py_s12   <= tr_out.o.py;
		head_s12 <= tr_out.o.zero ? '0 : tr_out.o.head;
		spd_s12  <= tr_out.o.spd;
		turn_s12 <= turn_w;
		zero_s12 <= tr_out.o.zero;
	end

	assign done       = done_s12;
	assign pos_x      = $signed(px_s12);
	assign pos_y      = $signed(py_s12);
	assign heading    = $signed(head_s12);
	assign speed      = spd_s12;
	assign turn_rate  = $signed(turn_s12);
	assign zero_speed = zero_s12;

	// Standstill forces heading and turn rate to zero
	a_zero_forces: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_speed) |-> (heading == '0 && turn_rate == '0))
		else $error("standstill item with non-zero heading or turn rate");

	// The standstill flag marks exactly the items with zero speed
	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (zero_speed == (speed == '0)))
		else $error("standstill flag disagrees with speed");

endmodule

/* sim/tb_figure_eight_trajectory_generator_top.sv */
// Self-checking testbench for the figure-eight trajectory generator top level.
// Depends on feq_pkg and the RTL top; predicts every result in fixed point and checks it.
`timescale 1ns / 1ps

module tb_figure_eight_trajectory_generator_top;

	import feq_pkg::*;

	localparam int        ROT_STAGES   = 20;
	localparam int        WATCHDOG_MAX = 5000;
	localparam int        DRAIN_CYCLES = 300;
	localparam longint    K_GAIN       = 64'sd652032874;
	localparam longint    K_2PI_Q28    = 64'sd1686629713;
	localparam longint    K_2PI_Q26    = 64'sd421657428;
	localparam longint    K_HALF       = 64'sd2147483648;
	localparam longint    K_QUARTER    = 64'sd1073741824;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [18:0] hd;
		logic        [30:0] sp;
		logic signed [31:0] tr;
		logic               zs;
	} pose_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [31:0]        time_now = '0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;
	logic               done;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [18:0] heading;
	logic [30:0]        speed;
	logic signed [31:0] turn_rate;
	logic               zero_speed;

	// Shadow copy of the configuration
	logic [31:0] sh_cx = '0;
	logic [31:0] sh_cy = '0;
	logic [30:0] sh_r  = 31'd65536;
	logic [30:0] sh_p  = 31'd655360;

	pose_t  pose_q[$];
	int     n_bad = 0;
	int     idle_cycles = 0;
	int     burst_left = 0;
	bit     no_gaps = 0;

	longint atan_tab[32] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
		64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
		64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
		64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001,
		64'h0, 64'h0
	};

	figure_eight_trajectory_generator_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .time_now(time_now),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
		.pos_x(pos_x), .pos_y(pos_y), .heading(heading), .speed(speed),
		.turn_rate(turn_rate), .zero_speed(zero_speed)
	);

	always #4 clk = ~clk;

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Rotation CORDIC on a turn fraction, folded into the right half plane
	function automatic void rot_sincos(input logic [31:0] ph, output longint c,
			output longint s);
		longint z, x, y, nx;
		bit neg;
		z = longint'($signed(ph));
		x = K_GAIN;
		y = 0;
		neg = 0;
		if (z > K_QUARTER) begin
			z -= K_HALF;
			neg = 1;
		end else if (z < -K_QUARTER) begin
			z += K_HALF;
			neg = 1;
		end
		for (int i = 0; i < ROT_STAGES; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				z -= atan_tab[i];
			end else begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				z += atan_tab[i];
			end
			x = nx;
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
	endfunction

	// Vectoring CORDIC: angle of (a, b) in turn units
	function automatic longint vec_angle(input longint b, input longint a);
		longint z, na;
		z = 0;
		if (a < 0) begin
			z = (b >= 0) ? K_HALF : -K_HALF;
			a = -a;
			b = -b;
		end
		for (int i = 0; i < ROT_STAGES; i++) begin
			if (b > 0) begin
				na = a + (b >>> i);
				b  = b - (a >>> i);
				z += atan_tab[i];
			end else begin
				na = a - (b >>> i);
				b  = b + (a >>> i);
				z -= atan_tab[i];
			end
			a = na;
		end
		if (z > K_HALF) z = K_HALF;
		if (z < -K_HALF) z = -K_HALF;
		return z;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res, bt;
		res = 0;
		bt  = 64'h4000000000000000;
		while (bt > v) bt >>= 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v  -= res + bt;
				res = (res >> 1) + bt;
			end else begin
				res >>= 1;
			end
			bt >>= 2;
		end
		return res;
	endfunction

	// Pose, heading, speed and turn rate for one time sample at the current settings
	function automatic pose_t figure_pose(input logic [31:0] t_in);
		longint unsigned t, p, d, m, spd;
		longint r, c1, s1, c2, s2, px, py, a, b, num, dd, rq, tr, hd, tn;
		logic [31:0] ph, ph2;
		pose_t o;
		t  = t_in;
		p  = (sh_p != 0) ? longint'(sh_p) : 1;
		r  = longint'(sh_r);
		ph = 32'(((t % p) << 32) / p);
		ph2 = {ph[30:0], 1'b0};
		rot_sincos(ph, c1, s1);
		rot_sincos(ph2, c2, s2);
		px = clamp32(longint'($signed(sh_cx)) + ((3 * r * s1 + (64'sd1 << 30)) >>> 31));
		py = clamp32(longint'($signed(sh_cy)) + ((r * s2 + (64'sd1 << 29)) >>> 30));
		a = (3 * c1) >>> 1;
		b = 2 * c2;
		d = longint'(a * a) + longint'(b * b);
		m = int_sqrt(d);
		spd = ((longint'(r) * m) >> 30) * longint'(K_2PI_Q28);
		spd = spd / (p << 12);
		o.zs = (spd == 0);
		if (spd > 64'd2147483647) spd = 64'd2147483647;
		hd = 0;
		tn = 0;
		if (!o.zs) begin
			hd  = (vec_angle(b, a) * K_2PI_Q28 + (64'sd1 << 43)) >>> 44;
			num = 3 * (s1 >>> 2) * (c2 >>> 2) - 6 * (c1 >>> 2) * (s2 >>> 2);
			dd  = longint'(d >> 34);
			if (dd < 1) dd = 1;
			rq  = num / dd;
			tr  = (rq * K_2PI_Q26) / longint'(p);
			tn  = clamp32(tr / 64'sd16777216);
		end
		o.px = px[31:0];
		o.py = py[31:0];
		o.hd = hd[18:0];
		o.sp = spd[30:0];
		o.tr = tn[31:0];
		return o;
	endfunction

	// Check each result against the oldest expected pose
	always @(posedge clk) begin
		pose_t e;
		bit bad;
		if (arst_n && done) begin
			if (pose_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10) $display("unexpected result: x=%0d y=%0d", pos_x, pos_y);
			end else begin
				e = pose_q.pop_front();
				bad = (pos_x !== e.px) || (pos_y !== e.py) || (heading !== e.hd) ||
					(speed !== e.sp) || (turn_rate !== e.tr) || (zero_speed !== e.zs);
				if (bad) begin
					n_bad++;
					if (n_bad <= 10)
						$display("mismatch: x %0d/%0d y %0d/%0d hd %0d/%0d sp %0d/%0d tr %0d/%0d z %0b/%0b",
							e.px, pos_x, e.py, pos_y, e.hd, heading, e.sp, speed,
							e.tr, turn_rate, e.zs, zero_speed);
				end
			end
		end
	end

	// Watchdog on cycles with no item accepted and no result
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_MAX) begin
			$display("tb_figure_eight_trajectory_generator_top: FAIL");
			$finish;
		end
	end

	// Hold start low for a random gap when the current burst runs out
	task automatic pace();
		int gap;
		if (no_gaps) return;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
			repeat (gap) begin
				@(negedge clk);
				start = 1'b0;
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
	endtask

	// Offer one time sample and record its expected pose once taken
	task automatic send_time(input logic [31:0] t);
		pace();
		@(negedge clk);
		start    = 1'b1;
		time_now = t;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		pose_q.push_back(figure_pose(t));
	endtask

	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (pose_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Write one register with the block idle and track it in the shadow copy
	task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
		drain();
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_CENTER_X: sh_cx = val;
			CFG_CENTER_Y: sh_cy = val;
			CFG_RADIUS:   sh_r  = val[30:0];
			CFG_PERIOD:   sh_p  = val[30:0];
		endcase
	endtask

	task automatic set_all(input logic [31:0] cx, input logic [31:0] cy,
			input logic [31:0] r, input logic [31:0] p);
		write_reg(CFG_CENTER_X, cx);
		write_reg(CFG_CENTER_Y, cy);
		write_reg(CFG_RADIUS, r);
		write_reg(CFG_PERIOD, p);
	endtask

	// Reset settings: quarter turns and the extremes of time
	task automatic test_reset_defaults();
		send_time(32'd0);
		send_time(32'd1);
		send_time(32'd163840);
		send_time(32'd327680);
		send_time(32'd491520);
		send_time(32'd655359);
		send_time(32'hFFFFFFFF);
		send_time(32'h80000000);
	endtask

	// Zero radius, zero period, saturation at large radius and centre extremes
	task automatic test_special_cases();
		write_reg(CFG_RADIUS, 32'd0);
		send_time(32'd12345);
		send_time(32'd200000);
		write_reg(CFG_PERIOD, 32'd0);
		write_reg(CFG_RADIUS, 32'd65536);
		send_time(32'd7);
		send_time(32'hFFFFFFFF);
		set_all(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'd1);
		send_time(32'd0);
		send_time(32'hAAAAAAAA);
		set_all(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		send_time(32'h20000000);
		send_time(32'h60000000);
		send_time(32'hFFFFFFFF);
		set_all(32'h0, 32'h0, 32'd1, 32'h7FFFFFFF);
		send_time(32'h12345678);
		send_time(32'h55555555);
	endtask

	// Random settings per phase, times spread over the figure and beyond
	task automatic test_random_phases();
		logic [31:0] t, pr;
		for (int ph = 0; ph < 6; ph++) begin
			pr = (ph == 0) ? 32'd655360 : ($urandom_range(0, 1) ? $urandom : $urandom_range(1, 1 << 22));
			set_all($urandom, $urandom,
				(ph == 5) ? $urandom_range(0, 4) : ($urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 20)),
				pr);
			no_gaps = (ph == 2);
			for (int k = 0; k < 320; k++) begin
				case ($urandom_range(0, 3))
					0: t = $urandom;
					1: t = $urandom_range(0, pr[30:0] * 2 + 1);
					2: t = pr[30:0] * $urandom_range(0, 3) + $urandom_range(0, 3);
					default: t = $urandom_range(0, 1) ? $urandom_range(0, 255) : ~$urandom_range(0, 255);
				endcase
				send_time(t);
			end
		end
		no_gaps = 0;
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_special_cases();
		test_random_phases();
		drain();
		if (n_bad == 0) begin
			$display("tb_figure_eight_trajectory_generator_top: PASS");
		end else begin
			$display("tb_figure_eight_trajectory_generator_top: FAIL");
		end
		$finish;
	end

endmodule
